FILE: design/utf8_to_ucs2_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_unit_macros
// Assertion macros shared by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_UNIT_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define U2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define U2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define U2D_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/u2d_pkg.sv
// ----------------------------------------------------------------------------
// u2d_pkg
// Types, constants and helpers of the UTF-8 to 16-bit unit decoder.
// ----------------------------------------------------------------------------
package u2d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 1'd1;

  localparam logic [7:0] ASCII_END   = 8'h80;
  localparam logic [7:0] CONT_TOP    = 8'h80 + 8'h40;
  localparam logic [7:0] LEAD2_END   = 8'h80 + 8'h40 + 8'h20;
  localparam logic [7:0] LEAD2_MASK  = 8'h1F;
  localparam logic [7:0] LEAD3_MASK  = 8'h0F;
  localparam logic [7:0] TRAIL_MASK  = 8'h3F;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam logic KIND_UNIT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } u2d_in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] code_unit;
    logic [15:0] unit_count;
    logic [15:0] unused_bytes;
    logic        run_end;
  } u2d_out_t;

  typedef struct packed {
    logic        unit_valid;
    logic [15:0] code_unit;
    logic        sum_valid;
    logic [15:0] unit_count;
    logic [15:0] unused_bytes;
  } u2d_entry_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [1:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {15'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

FILE: design/u2d_front.sv
// ----------------------------------------------------------------------------
// u2d_front
// Takes one byte a cycle while accept is high, tracks the open sequence and
// string counters, and queues the unit and summary it yields.
// ----------------------------------------------------------------------------
module u2d_front
  import u2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  u2d_in_t     in_word,
  input  logic        byte_swap,
  input  logic [15:0] out_limit,
  output logic        q_push,
  output u2d_entry_t  q_entry
);

  logic [7:0]  lead_r, lead_nxt, lead_s;
  logic [7:0]  mid_r, mid_nxt, mid_s;
  logic [1:0]  pend_r, pend_nxt, pend_s;
  logic [15:0] units_r, units_nxt, units_s;
  logic [15:0] tally_r, tally_nxt, tally_s;
  logic        halted_r, halted_nxt, halted_s;

  logic        count_mode;
  logic        have_unit;
  logic        count_hit;
  logic [15:0] unit;
  logic [7:0]  b;
  logic [1:0]  held;

  assign b          = in_word.in_byte;
  assign count_mode = (out_limit == 16'd0);

  always_comb begin
    lead_s    = lead_r;
    mid_s     = mid_r;
    pend_s    = pend_r;
    tally_s   = tally_r;
    halted_s  = halted_r;
    have_unit = 1'b0;
    count_hit = 1'b0;
    unit      = 16'd0;
    if (count_mode) begin
      count_hit = (b < ASCII_END) || (b > CONT_TOP);
    end else if (halted_r) begin
      tally_s = sat_add16(tally_r, 2'd1);
    end else begin
      case (pend_r)
        PEND_NONE: begin
          if (b < ASCII_END) begin
            unit      = {8'd0, b};
            have_unit = 1'b1;
          end else begin
            lead_s = b;
            pend_s = (b < LEAD2_END) ? PEND_ONE : PEND_TWO;
          end
        end
        PEND_TWO: begin
          mid_s  = b;
          pend_s = PEND_ONE;
        end
        default: begin
          if (lead_r < LEAD2_END) begin
            unit = {5'd0, lead_r[4:0] & LEAD2_MASK[4:0], b[5:0] & TRAIL_MASK[5:0]};
          end else begin
            unit = {lead_r[3:0] & LEAD3_MASK[3:0], mid_r[5:0] & TRAIL_MASK[5:0],
                    b[5:0] & TRAIL_MASK[5:0]};
          end
          have_unit = 1'b1;
          pend_s    = PEND_NONE;
          lead_s    = 8'd0;
          mid_s     = 8'd0;
        end
      endcase
    end
    units_s = (have_unit || count_hit) ? sat_add16(units_r, 2'd1) : units_r;
    if (have_unit && (units_s >= out_limit)) begin
      halted_s = 1'b1;
    end
  end

  always_comb begin
    case (pend_s)
      PEND_TWO: held = 2'd1;
      PEND_ONE: held = (lead_s < LEAD2_END) ? 2'd1 : 2'd2;
      default:  held = 2'd0;
    endcase
  end

  always_comb begin
    q_entry.unit_valid   = have_unit;
    q_entry.code_unit    = byte_swap ? {unit[7:0], unit[15:8]} : unit;
    q_entry.sum_valid    = in_word.last_byte;
    q_entry.unit_count   = units_s;
    q_entry.unused_bytes = count_mode ? 16'd0 : sat_add16(tally_s, held);
    q_push               = accept && (have_unit || in_word.last_byte);
  end

  always_comb begin
    lead_nxt   = lead_r;
    mid_nxt    = mid_r;
    pend_nxt   = pend_r;
    units_nxt  = units_r;
    tally_nxt  = tally_r;
    halted_nxt = halted_r;
    if (accept) begin
      if (in_word.last_byte) begin
        lead_nxt   = 8'd0;
        mid_nxt    = 8'd0;
        pend_nxt   = PEND_NONE;
        units_nxt  = 16'd0;
        tally_nxt  = 16'd0;
        halted_nxt = 1'b0;
      end else begin
        lead_nxt   = lead_s;
        mid_nxt    = mid_s;
        pend_nxt   = pend_s;
        units_nxt  = units_s;
        tally_nxt  = tally_s;
        halted_nxt = halted_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= 8'd0;
      mid_r    <= 8'd0;
      pend_r   <= PEND_NONE;
      units_r  <= 16'd0;
      tally_r  <= 16'd0;
      halted_r <= 1'b0;
    end else begin
      lead_r   <= lead_nxt;
      mid_r    <= mid_nxt;
      pend_r   <= pend_nxt;
      units_r  <= units_nxt;
      tally_r  <= tally_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

FILE: design/u2d_queue.sv
// ----------------------------------------------------------------------------
// u2d_queue
// Small register queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module u2d_queue
  import u2d_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  u2d_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       valid,
  output u2d_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  u2d_entry_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign valid   = (cnt_r != '0);
  assign head    = slots_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push_entry;
    end
  end

endmodule

FILE: design/u2d_back.sv
// ----------------------------------------------------------------------------
// u2d_back
// Holds the current entry and hands out its unit and summary words in order.
// ----------------------------------------------------------------------------
module u2d_back
  import u2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  u2d_entry_t q_head,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output u2d_out_t   out_word
);

  u2d_entry_t cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic       sub_r, sub_nxt;
  logic       show_unit;
  logic       taken;
  logic       done;
  logic       load;

  assign show_unit = cur_r.unit_valid && !sub_r;
  assign taken     = out_pop && cur_valid_r;
  assign done      = taken && (!show_unit || !cur_r.sum_valid);
  assign load      = q_valid && (!cur_valid_r || done);
  assign q_pop     = load;
  assign out_empty = !cur_valid_r;

  always_comb begin
    out_word.kind         = show_unit ? KIND_UNIT : KIND_SUMMARY;
    out_word.code_unit    = show_unit ? cur_r.code_unit : 16'd0;
    out_word.unit_count   = show_unit ? 16'd0 : cur_r.unit_count;
    out_word.unused_bytes = show_unit ? 16'd0 : cur_r.unused_bytes;
    out_word.run_end      = show_unit ? !cur_r.sum_valid : 1'b1;
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    sub_nxt       = sub_r;
    if (load) begin
      cur_nxt       = q_head;
      cur_valid_nxt = 1'b1;
      sub_nxt       = 1'b0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (taken) begin
      sub_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

FILE: design/utf8_to_ucs2_decoder_unit.sv
// An accepted byte's entry is registered in the queue, then in the back stage.
// Throughput: one byte per cycle unless in_full; a final byte completing a unit
// yields two words and takes two pops, the entry queue absorbs the burst.
// The queue depth (QUEUE_DEPTH entries) sets how long a stalled output is hidden.
// Reset (synchronous, rst_n low) clears config, sequence state and the queue.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_unit
// Lenient UTF-8 to 16-bit unit decoder with configuration port.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_unit
  import u2d_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  u2d_in_t               in_word,
  output logic                  out_empty,
  input  logic                  out_pop,
  output u2d_out_t              out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        byte_swap_r, byte_swap_nxt;
  logic [15:0] out_limit_r, out_limit_nxt;
  logic        accept;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  u2d_entry_t  q_entry;
  u2d_entry_t  q_head;

  assign accept = in_push && !in_full;

  always_comb begin
    byte_swap_nxt = byte_swap_r;
    out_limit_nxt = out_limit_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BYTE_SWAP: byte_swap_nxt = cfg_wdata[0];
        CFG_OUT_LIMIT: out_limit_nxt = cfg_wdata[15:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_swap_r <= 1'b0;
      out_limit_r <= 16'd0;
    end else begin
      byte_swap_r <= byte_swap_nxt;
      out_limit_r <= out_limit_nxt;
    end
  end

  u2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_word),
    .byte_swap (byte_swap_r),
    .out_limit (out_limit_r),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  u2d_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (in_full),
    .valid      (q_valid),
    .head       (q_head)
  );

  u2d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

FILE: design/u2d_checker.sv
// ----------------------------------------------------------------------------
// u2d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_ucs2_decoder_unit_macros.svh"

module u2d_checker
  import u2d_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_full,
  input logic     out_empty,
  input logic     out_pop,
  input u2d_out_t out_word
);

  `U2D_ASSERT_NOW(a_summary_shape, !out_empty && (out_word.kind == KIND_SUMMARY), (out_word.code_unit == 16'd0) && out_word.run_end, "summary word with unit data or without run end")

  `U2D_ASSERT_NOW(a_unit_shape, !out_empty && (out_word.kind == KIND_UNIT), (out_word.unit_count == 16'd0) && (out_word.unused_bytes == 16'd0), "unit word with summary data")

  `U2D_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_word), "waiting word changed or vanished")

  `U2D_ASSERT_ALWAYS_NEXT(a_reset_clear, !rst_n, out_empty && !in_full, "reset left words or a full queue")

endmodule

bind utf8_to_ucs2_decoder_unit u2d_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_word  (out_word)
);
